// File: rtl/scaa_pkg.sv
// ----------------------------------------------------------------------------
// Size-class arena allocator package
// Shared field widths, operation codes and the block selection record.
// ----------------------------------------------------------------------------
package scaa_pkg;

  localparam int REQ_LEN_W  = 32;
  localparam int BLK_IDX_W  = 5;
  localparam int BYTE_OFF_W = 26;

  typedef enum logic {
    OP_ALLOC   = 1'b0,
    OP_RELEASE = 1'b1
  } op_t;

  typedef struct packed {
    logic                 hit;
    logic [BLK_IDX_W-1:0] idx;
    logic                 fresh;
  } sel_t;

endpackage

// File: rtl/scaa_select.sv
// ----------------------------------------------------------------------------
// Size-class arena allocator block selection
// Finds the lowest block whose remaining room holds the requested length.
// ----------------------------------------------------------------------------
module scaa_select #(
  parameter int FIRST_SIZE = 64,
  parameter int NUM_BLOCKS = 20,
  parameter int OFF_W      = 26
) (
  input  logic [scaa_pkg::REQ_LEN_W-1:0]        req_len,
  input  logic [NUM_BLOCKS-1:0][OFF_W-1:0]      fill_i,
  input  logic [NUM_BLOCKS-1:0]                 live_i,
  output scaa_pkg::sel_t                        sel_o,
  output logic [OFF_W-1:0]                      start_o
);
  import scaa_pkg::*;

  localparam int SUM_W = ((OFF_W > REQ_LEN_W) ? OFF_W : REQ_LEN_W) + 1;

  logic [NUM_BLOCKS-1:0] fit;
  logic [SUM_W-1:0]      size_w;

  always_comb begin
    fit    = '0;
    size_w = '0;
    for (int i = 0; i < NUM_BLOCKS; i++) begin
      size_w = SUM_W'(FIRST_SIZE) << i;
      fit[i] = (SUM_W'(fill_i[i]) + SUM_W'(req_len)) <= size_w;
    end
  end

  always_comb begin
    sel_o   = '0;
    start_o = '0;
    for (int i = NUM_BLOCKS - 1; i >= 0; i--) begin
      if (fit[i]) begin
        sel_o.hit   = 1'b1;
        sel_o.idx   = BLK_IDX_W'(i);
        sel_o.fresh = !live_i[i];
        start_o     = fill_i[i];
      end
    end
  end

endmodule

// File: rtl/size_class_arena_allocator.sv
// ----------------------------------------------------------------------------
// Size-class arena allocator
// Bump allocator over blocks of doubling size with a release of all blocks.
// ----------------------------------------------------------------------------
//  Channel | Direction | Contents
//  in_     | slave     | tuser: op; tdata: req_len
//  out_    | master    | tuser: ok; tdata: block_index, byte_offset, new_block
//
// An item is taken every cycle while the receiver keeps up; it passes through
// the input register and then the result register, from which it is offered.
// The per-block add and compare with the lowest-index pick sets the cycle.
// Reset empties every block at once and needs no clearing pass.
// While out_tready is low a waiting result holds, and in_tready falls once the
// input and result registers are both full.
module size_class_arena_allocator #(
  parameter int FIRST_SIZE = 64,
  parameter int NUM_BLOCKS = 20
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // req_len
  input  logic        in_tuser,   // op
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // block_index, byte_offset, new_block
  output logic        out_tuser   // ok
);
  import scaa_pkg::*;

  localparam longint MAX_SIZE = longint'(FIRST_SIZE) << (NUM_BLOCKS - 1);
  localparam int     OFF_W    = $clog2(MAX_SIZE + 1);
  localparam int     SUM_W    = ((OFF_W > REQ_LEN_W) ? OFF_W : REQ_LEN_W) + 1;
  localparam int     IX_W     = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;

  logic                            s1_valid_r, s1_valid_nxt;
  op_t                             s1_op_r;
  logic [REQ_LEN_W-1:0]            s1_len_r;

  logic                            out_valid_r, out_valid_nxt;
  logic                            out_ok_r, out_ok_nxt;
  logic [BLK_IDX_W-1:0]            out_idx_r, out_idx_nxt;
  logic [BYTE_OFF_W-1:0]           out_off_r, out_off_nxt;
  logic                            out_new_r, out_new_nxt;

  logic [NUM_BLOCKS-1:0][OFF_W-1:0] fill_r;
  logic [NUM_BLOCKS-1:0]            live_r;
  logic [NUM_BLOCKS-1:0]            fill_nz;

  logic                            res_ready, in_fire, s1_fire;
  sel_t                            sel;
  logic [OFF_W-1:0]                start;
  logic [OFF_W-1:0]                fill_nxt;

  assign res_ready = !out_valid_r || out_tready;
  assign in_tready = !s1_valid_r || res_ready;
  assign in_fire   = in_tvalid && in_tready;
  assign s1_fire   = s1_valid_r && res_ready;

  scaa_select #(
    .FIRST_SIZE (FIRST_SIZE),
    .NUM_BLOCKS (NUM_BLOCKS),
    .OFF_W      (OFF_W)
  ) u_select (
    .req_len (s1_len_r),
    .fill_i  (fill_r),
    .live_i  (live_r),
    .sel_o   (sel),
    .start_o (start)
  );

  assign fill_nxt = OFF_W'(SUM_W'(start) + SUM_W'(s1_len_r));

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_fire) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_fire) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_ok_nxt    = out_ok_r;
    out_idx_nxt   = out_idx_r;
    out_off_nxt   = out_off_r;
    out_new_nxt   = out_new_r;
    if (s1_fire) begin
      out_valid_nxt = 1'b1;
      out_ok_nxt    = 1'b0;
      out_idx_nxt   = '0;
      out_off_nxt   = '0;
      out_new_nxt   = 1'b0;
      if (s1_op_r == OP_RELEASE) begin
        out_ok_nxt = 1'b1;
      end else if (sel.hit) begin
        out_ok_nxt  = 1'b1;
        out_idx_nxt = sel.idx;
        out_off_nxt = BYTE_OFF_W'(start);
        out_new_nxt = sel.fresh;
      end
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_op_r  <= op_t'(in_tuser);
      s1_len_r <= in_tdata;
    end
    out_ok_r  <= out_ok_nxt;
    out_idx_r <= out_idx_nxt;
    out_off_r <= out_off_nxt;
    out_new_r <= out_new_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
      live_r <= '0;
    end else if (s1_fire) begin
      if (s1_op_r == OP_RELEASE) begin
        fill_r <= '0;
        live_r <= '0;
      end else if (sel.hit) begin
        fill_r[sel.idx[IX_W-1:0]] <= fill_nxt;
        live_r[sel.idx[IX_W-1:0]] <= 1'b1;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_ok_r;
  assign out_tdata  = {out_new_r, out_off_r, out_idx_r};

  always_comb begin
    for (int i = 0; i < NUM_BLOCKS; i++) begin
      fill_nz[i] = |fill_r[i];
    end
  end

  a_idle_block_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (fill_nz & ~live_r) == '0)
    else $error("A block out of use holds a non-zero fill offset.");

  a_release_clears: assert property (@(posedge clk) disable iff (!rst_n)
    s1_fire && s1_op_r == OP_RELEASE |=> live_r == '0 && out_tuser)
    else $error("A release did not empty every block.");

  a_miss_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ok_r |-> out_tdata == '0)
    else $error("A failed request carries non-zero result fields.");

  a_new_block_live: assert property (@(posedge clk) disable iff (!rst_n)
    s1_fire && s1_op_r == OP_ALLOC && sel.hit && sel.fresh |=> out_new_r && out_ok_r)
    else $error("A fresh block was served without the new-block flag.");

endmodule

// File: verif/size_class_arena_allocator_tb.sv
// ----------------------------------------------------------------------------
// Size-class arena allocator testbench
// Drives allocate and release items with random gaps, predicts each grant by
// tracking the fill offset and live flag of every block, and compares each
// result field by field in arrival order. The receiver stalls at random and
// once holds off long enough for the block to stop taking input.
// ----------------------------------------------------------------------------
module size_class_arena_allocator_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import scaa_pkg::*;

  localparam int FIRST_SIZE = 64;
  localparam int NUM_BLOCKS = 20;
  localparam int MAX_REPORTS = 10;

  typedef struct packed {
    op_t         op;
    logic [31:0] len;
  } alloc_req_t;

  typedef struct packed {
    logic                  ok;
    logic [BLK_IDX_W-1:0]  idx;
    logic [BYTE_OFF_W-1:0] off;
    logic                  nb;
  } grant_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;
  logic        in_tuser = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;
  logic        out_tuser;

  logic [63:0] blk_fill [NUM_BLOCKS];
  logic        blk_live [NUM_BLOCKS];

  alloc_req_t req_backlog[$];
  grant_t     pending_grants[$];
  alloc_req_t cur_req;

  int  send_gap = 0;
  int  sink_wait = 0;
  int  n_sent = 0;
  int  n_granted = 0;
  int  n_errors = 0;
  int  n_served = 0;
  int  n_refused = 0;
  int  n_releases = 0;
  int  n_fresh = 0;
  int  sink_cycles = 0;
  logic hold_off = 1'b0;

  size_class_arena_allocator #(
    .FIRST_SIZE(FIRST_SIZE),
    .NUM_BLOCKS(NUM_BLOCKS)
  ) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  always #1 clk = ~clk;

  function automatic void clear_blocks();
    for (int i = 0; i < NUM_BLOCKS; i++) begin
      blk_fill[i] = '0;
      blk_live[i] = 1'b0;
    end
  endfunction

  function automatic grant_t serve_request(alloc_req_t req);
    grant_t      g;
    logic [63:0] size;
    logic [63:0] start;
    logic        fresh;
    g = '0;
    if (req.op == OP_RELEASE) begin
      clear_blocks();
      g.ok = 1'b1;
      n_releases++;
      return g;
    end
    for (int i = 0; i < NUM_BLOCKS; i++) begin
      size = 64'(FIRST_SIZE) << i;
      if (64'(req.len) > size) continue;
      fresh = 1'b0;
      if (!blk_live[i]) begin
        blk_live[i] = 1'b1;
        blk_fill[i] = '0;
        fresh = 1'b1;
      end
      start = blk_fill[i];
      if (start + 64'(req.len) > size) continue;
      blk_fill[i] = start + 64'(req.len);
      g.ok = 1'b1;
      g.idx = i[BLK_IDX_W-1:0];
      g.off = start[BYTE_OFF_W-1:0];
      g.nb = fresh;
      n_served++;
      if (fresh) n_fresh++;
      return g;
    end
    n_refused++;
    return g;
  endfunction

  function automatic int pick_gap(int phase_count);
    int r;
    r = $urandom_range(0, 99);
    if (((phase_count / 64) % 4) == 1) return 0;
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(5, 30);
  endfunction

  function automatic void add_req(op_t op, logic [31:0] len);
    alloc_req_t req;
    req.op = op;
    req.len = len;
    req_backlog.push_back(req);
  endfunction

  task automatic check_grant();
    grant_t got;
    grant_t want;
    got.ok = out_tuser;
    got.idx = out_tdata[BLK_IDX_W-1:0];
    got.off = out_tdata[BLK_IDX_W +: BYTE_OFF_W];
    got.nb = out_tdata[BLK_IDX_W + BYTE_OFF_W];
    n_granted++;
    if (pending_grants.size() == 0) begin
      n_errors++;
      if (n_errors <= MAX_REPORTS)
        $display("Unexpected result: ok=%0b idx=%0d off=%0d new=%0b",
                 got.ok, got.idx, got.off, got.nb);
      return;
    end
    want = pending_grants.pop_front();
    if (got.ok !== want.ok || got.idx !== want.idx || got.off !== want.off ||
        got.nb !== want.nb) begin
      n_errors++;
      if (n_errors <= MAX_REPORTS)
        $display({"Result %0d mismatch: expected ok=%0b idx=%0d off=%0d new=%0b, ",
                  "got ok=%0b idx=%0d off=%0d new=%0b"},
                 n_granted, want.ok, want.idx, want.off, want.nb,
                 got.ok, got.idx, got.off, got.nb);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata <= '0;
      in_tuser <= 1'b0;
      send_gap = 0;
    end else begin
      if (in_tvalid && in_tready) begin
        pending_grants.push_back(serve_request(cur_req));
        n_sent++;
      end
      if (!(in_tvalid && !in_tready)) begin
        if (send_gap > 0) begin
          send_gap--;
          in_tvalid <= 1'b0;
        end else if (req_backlog.size() > 0) begin
          cur_req = req_backlog.pop_front();
          in_tvalid <= 1'b1;
          in_tuser <= cur_req.op;
          in_tdata <= cur_req.len;
          send_gap = pick_gap(n_sent);
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      sink_wait = 0;
    end else begin
      sink_cycles++;
      if (out_tvalid && out_tready) check_grant();
      if (sink_wait > 0) sink_wait--;
      else sink_wait = pick_gap(sink_cycles / 2);
      out_tready <= !hold_off && (sink_wait == 0);
    end
  end

  initial begin
    wait (n_granted >= 300);
    @(posedge clk);
    hold_off <= 1'b1;
    repeat (200) @(posedge clk);
    hold_off <= 1'b0;
  end

  initial begin
    #2_000_000;
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    int          r;
    int          k;
    logic [31:0] len;
    clear_blocks();
    add_req(OP_ALLOC, 32'd0);
    add_req(OP_ALLOC, 32'd1);
    add_req(OP_ALLOC, 32'd63);
    add_req(OP_ALLOC, 32'd0);
    add_req(OP_ALLOC, 32'd1);
    add_req(OP_ALLOC, 32'd64);
    add_req(OP_ALLOC, 32'd65);
    add_req(OP_ALLOC, 32'd33554432);
    add_req(OP_ALLOC, 32'd33554432);
    add_req(OP_ALLOC, 32'd33554433);
    add_req(OP_ALLOC, 32'hFFFF_FFFF);
    add_req(OP_RELEASE, 32'hFFFF_FFFF);
    add_req(OP_ALLOC, 32'd0);
    add_req(OP_RELEASE, 32'd0);
    add_req(OP_ALLOC, 32'd64);
    add_req(OP_ALLOC, 32'h8000_0000);
    add_req(OP_ALLOC, 32'h5555_5555);
    add_req(OP_ALLOC, 32'hAAAA_AAAA);
    add_req(OP_RELEASE, 32'hAAAA_5555);
    add_req(OP_ALLOC, 32'd128);
    for (int n = 0; n < 930; n++) begin
      r = $urandom_range(0, 99);
      if (r < 3) begin
        add_req(OP_RELEASE, $urandom);
      end else if (r < 8) begin
        add_req(OP_ALLOC, $urandom);
      end else if (r < 18) begin
        len = 32'(FIRST_SIZE) << $urandom_range(0, NUM_BLOCKS - 1);
        add_req(OP_ALLOC, len);
      end else begin
        k = $urandom_range(0, 25);
        len = $urandom_range(0, 32'd1 << k);
        add_req(OP_ALLOC, len);
      end
    end

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    while (req_backlog.size() != 0 || in_tvalid) @(posedge clk);
    while (pending_grants.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("Sent %0d items: %0d served (%0d opened a block), %0d refused, %0d releases.",
             n_sent, n_served, n_fresh, n_refused, n_releases);
    $display("Checked %0d results with random stalls and one long receiver hold-off.",
             n_granted);
    if (n_errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches in total.", n_errors);
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
